### sv/dts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;
  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned MaxEdgesDef = 256;
  localparam int unsigned NodeW = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_ROOT,
    ST_TOP_RD,
    ST_TOP_EVAL,
    ST_EDGE_EVAL,
    ST_PUSH_RD,
    ST_PUSH,
    ST_EMIT_RD,
    ST_EMIT,
    ST_CLEAR
  } state_t;
endpackage
`default_nettype wire

### sv/dts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/dfs_topological_sort.sv
`timescale 1ns / 1ps
`default_nettype none
// depth-first topological sort engine
// start with kind=0 transfers one edge (from_node -> to_node); it is appended
// to the successor list of from_node; busy stays high after the transfer
// while it is written, also through ST_PUSH_RD when the list already has one.
// start with kind=1 runs the sort: a depth-first search from every unvisited
// node in ascending order, then node_count results in reverse finish order,
// each marked by valid for one cycle, last on the final one, edge_lost on all.
// busy stays high through a run, then while the list heads and visited marks
// are cleared.
// edges beyond MAX_EDGES or with a node >= node_count are dropped.
// cfg_we writes node_count (0 taken as 1, above MAX_NODES as MAX_NODES).
// reset: node_count = MAX_NODES, then a clearing pass over every node entry
// runs with busy high before the first item is taken.
// results cannot be stalled; the receiver takes each on the cycle it shows.
module dfs_topological_sort #(
  parameter int unsigned MAX_NODES = dts_pkg::MaxNodesDef,
  parameter int unsigned MAX_EDGES = dts_pkg::MaxEdgesDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         kind,
  input  wire logic [$clog2(MAX_NODES)-1:0] from_node,
  input  wire logic [$clog2(MAX_NODES)-1:0] to_node,
  input  wire logic                         cfg_we,
  input  wire logic [$clog2(MAX_NODES):0]   cfg_data,
  output logic                              valid,
  output logic      [$clog2(MAX_NODES)-1:0] node,
  output logic                              last,
  output logic                              edge_lost
);
  import dts_pkg::*;

  localparam int unsigned NA = $clog2(MAX_NODES);
  localparam int unsigned EA = $clog2(MAX_EDGES);
  localparam int unsigned EW = EA + 1;
  localparam int unsigned NW = NA + 1;
  localparam logic [EW-1:0] EmptyCode = EW'(MAX_EDGES);

  state_t state, state_next;
  logic [NW-1:0] ncount;
  logic [EW-1:0] used;
  logic          lost;
  logic [NW-1:0] root, sp, done, k;
  logic [NA-1:0] cur_from, cur_to;
  logic [EW-1:0] cur_e;
  logic [NA-1:0] push_t;

  // clearing sweep runs after reset and after emitting
  logic          wipe_on;
  logic [NW-1:0] wipe;

  // memories
  logic          hd_we;   logic [NA-1:0] hd_wa, hd_ra; logic [EW-1:0] hd_wd, hd_rd;
  logic          tl_we;   logic [NA-1:0] tl_wa, tl_ra; logic [EA-1:0] tl_wd, tl_rd;
  logic          tg_we;   logic [EA-1:0] tg_wa, tg_ra; logic [NA-1:0] tg_wd, tg_rd;
  logic          lk_we;   logic [EA-1:0] lk_wa, lk_ra; logic [EW-1:0] lk_wd, lk_rd;
  logic          vs_we;   logic [NA-1:0] vs_wa, vs_ra; logic           vs_wd, vs_rd;
  logic          sk_we;   logic [NA-1:0] sk_wa, sk_ra;
  logic [NA+EW-1:0] sk_wd, sk_rd;
  logic          fs_we;   logic [NA-1:0] fs_wa, fs_ra; logic [NA-1:0] fs_wd, fs_rd;

  dts_ram #(.Width(EW), .Depth(MAX_NODES)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
    .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  dts_ram #(.Width(EA), .Depth(MAX_NODES)) u_tail (.clk, .we(tl_we), .waddr(tl_wa),
    .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  dts_ram #(.Width(NA), .Depth(MAX_EDGES)) u_tgt (.clk, .we(tg_we), .waddr(tg_wa),
    .wdata(tg_wd), .raddr(tg_ra), .rdata(tg_rd));
  dts_ram #(.Width(EW), .Depth(MAX_EDGES)) u_link (.clk, .we(lk_we), .waddr(lk_wa),
    .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
  dts_ram #(.Width(1), .Depth(MAX_NODES)) u_vis (.clk, .we(vs_we), .waddr(vs_wa),
    .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd));
  dts_ram #(.Width(NA + EW), .Depth(MAX_NODES)) u_stk (.clk, .we(sk_we), .waddr(sk_wa),
    .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
  dts_ram #(.Width(NA), .Depth(MAX_NODES)) u_fin (.clk, .we(fs_we), .waddr(fs_wa),
    .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

  logic [NW-1:0] top;
  logic [NA-1:0] top_node;
  logic [EW-1:0] top_cur;
  logic          from_ok, to_ok, t_ok;
  logic [NW-1:0] cfg_sat;

  assign top      = sp - NW'(1);
  assign top_node = sk_rd[NA+EW-1:EW];
  assign top_cur  = sk_rd[EW-1:0];
  assign from_ok  = NW'(cur_from) < ncount;
  assign to_ok    = NW'(cur_to) < ncount;
  assign t_ok     = NW'(tg_rd) < ncount;
  assign busy     = (state != ST_IDLE) || wipe_on;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_sat = NW'(1);
    end else if (32'(cfg_data) > MAX_NODES) begin
      cfg_sat = NW'(MAX_NODES);
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_comb begin
    state_next = state;
    hd_we = 1'b0; hd_wa = cur_from; hd_wd = EW'(cur_e); hd_ra = cur_from;
    tl_we = 1'b0; tl_wa = cur_from; tl_wd = cur_e[EA-1:0]; tl_ra = cur_from;
    tg_we = 1'b0; tg_wa = cur_e[EA-1:0]; tg_wd = cur_to; tg_ra = top_cur[EA-1:0];
    lk_we = 1'b0; lk_wa = cur_e[EA-1:0]; lk_wd = EmptyCode; lk_ra = top_cur[EA-1:0];
    vs_we = 1'b0; vs_wa = root[NA-1:0]; vs_wd = 1'b1; vs_ra = root[NA-1:0];
    sk_we = 1'b0; sk_wa = top[NA-1:0]; sk_wd = '0; sk_ra = top[NA-1:0];
    fs_we = 1'b0; fs_wa = done[NA-1:0]; fs_wd = top_node;
    fs_ra = NA'(done - NW'(1) - k);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = kind ? ST_ROOT : ST_EDGE_RD;
          hd_ra = from_node;
          tl_ra = from_node;
          vs_ra = '0;
        end
      end
      ST_EDGE_RD: state_next = ST_EDGE_WR;
      ST_EDGE_WR: begin
        if (used < EmptyCode && from_ok && to_ok) begin
          tg_we = 1'b1;
          lk_we = 1'b1;
          tl_we = 1'b1;
          if (hd_rd >= EmptyCode) begin
            hd_we = 1'b1;
          end else begin
            lk_we = 1'b0;
            // link write of old tail shares the port; new entry link written later
            state_next = ST_PUSH_RD;
          end
        end
        if (state_next == ST_EDGE_WR) begin
          state_next = ST_IDLE;
        end
      end
      ST_PUSH_RD: begin
        // second half of an append: terminate new entry (old tail linked in ST_EDGE_WR)
        state_next = ST_IDLE;
      end
      ST_ROOT: begin
        // vs_rd holds visited mark of root
        if (root >= ncount) begin
          state_next = ST_EMIT_RD;
        end else if (vs_rd) begin
          vs_ra = NA'(root + NW'(1));
        end else begin
          vs_we = 1'b1;
          hd_ra = root[NA-1:0];
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        sk_we = 1'b1;
        sk_wa = sp[NA-1:0];
        sk_wd = {push_t, hd_rd};
        sk_ra = sp[NA-1:0];
        state_next = ST_TOP_RD;
      end
      ST_TOP_RD: state_next = ST_TOP_EVAL;
      ST_TOP_EVAL: begin
        if (top_cur < used) begin
          state_next = ST_EDGE_EVAL;
        end else begin
          fs_we = 1'b1;
          if (sp == NW'(1)) begin
            state_next = ST_ROOT;
            vs_ra = NA'(root + NW'(1));
          end else begin
            sk_ra = NA'(sp - NW'(2));
            state_next = ST_TOP_RD;
          end
        end
      end
      ST_EDGE_EVAL: begin
        sk_we = 1'b1;
        sk_wd = {top_node, lk_rd};
        vs_ra = tg_rd;
        hd_ra = tg_rd;
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (t_ok && !vs_rd && sp < NW'(MAX_NODES)) begin
          vs_we = 1'b1;
          vs_wa = push_t;
          state_next = ST_PUSH;
        end else begin
          state_next = ST_TOP_RD;
        end
      end
      ST_EMIT_RD: begin
        if (k >= done) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        fs_ra = NA'(done - NW'(2) - k);
        state_next = ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_PUSH_RD) begin
      lk_we = 1'b1;
      lk_wa = cur_e[EA-1:0];
      lk_wd = EmptyCode;
    end
    if (state == ST_EDGE_WR && state_next == ST_PUSH_RD) begin
      lk_we = 1'b1;
      lk_wa = tl_rd;
      lk_wd = cur_e;
    end
    if (state == ST_EDGE_EVAL || state == ST_CLEAR || state == ST_PUSH) begin
      if (state == ST_CLEAR) begin
        hd_ra = push_t;
      end
    end
    if (wipe_on) begin
      hd_we = 1'b1; hd_wa = wipe[NA-1:0]; hd_wd = EmptyCode;
      vs_we = 1'b1; vs_wa = wipe[NA-1:0]; vs_wd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= 1'b0;
      ncount  <= NW'(MAX_NODES);
      used    <= '0;
      lost    <= 1'b0;
      wipe_on <= 1'b1;
      wipe    <= '0;
      root <= '0; sp <= '0; done <= '0; k <= '0;
    end else begin
      valid <= !wipe_on && (state == ST_EMIT);
      if (cfg_we) begin
        ncount <= cfg_sat;
      end
      if (wipe_on) begin
        wipe <= wipe + NW'(1);
        if (wipe == NW'(MAX_NODES - 1)) begin
          wipe_on <= 1'b0;
        end
      end else begin
        state <= state_next;
      end
      if (!wipe_on) begin
        unique case (state)
          ST_IDLE: begin
            if (start) begin
              cur_from <= from_node;
              cur_to   <= to_node;
              cur_e    <= used;
              root <= '0; sp <= '0; done <= '0; k <= '0;
            end
          end
          ST_EDGE_WR: begin
            if (used < EmptyCode && from_ok && to_ok) begin
              used <= used + EW'(1);
            end else begin
              lost <= 1'b1;
            end
          end
          ST_ROOT: begin
            if (root < ncount) begin
              if (vs_rd) begin
                root <= root + NW'(1);
              end else begin
                push_t <= root[NA-1:0];
              end
            end
          end
          ST_PUSH: sp <= sp + NW'(1);
          ST_TOP_EVAL: begin
            if (!(top_cur < used)) begin
              done <= done + NW'(1);
              sp   <= sp - NW'(1);
              if (sp == NW'(1)) begin
                root <= root + NW'(1);
              end
            end
          end
          ST_EDGE_EVAL: push_t <= tg_rd;
          ST_EMIT_RD: begin
            if (k >= done) begin
              wipe_on <= 1'b1;
              wipe    <= '0;
              used    <= '0;
              lost    <= 1'b0;
            end
          end
          ST_EMIT: begin
            node      <= fs_rd;
            last      <= (k + NW'(1) == done);
            edge_lost <= lost;
            k         <= k + NW'(1);
          end
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) valid |-> $past(state) == ST_EMIT)
    else $error("result without emit");
  assert property (@(posedge clk) disable iff (rst) sp <= NW'(MAX_NODES))
    else $error("stack overflow");
  assert property (@(posedge clk) disable iff (rst) done <= NW'(MAX_NODES))
    else $error("too many finished nodes");
  assert property (@(posedge clk) disable iff (rst) used <= EmptyCode)
    else $error("edge pool overflow");
endmodule
`default_nettype wire

### bench/dfs_topological_sort_tb.sv
`timescale 1ns / 1ps
module dfs_topological_sort_tb;
  import dts_pkg::*;

  localparam int NODES = 64;
  localparam int EDGES = 256;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             last;
    logic             edge_lost;
  } order_t;

  typedef enum logic {K_EDGE = 1'b0, K_RUN = 1'b1} kind_e;

  logic clk = 0, rst = 1;
  logic start = 0, kind = 0, cfg_we = 0;
  logic [NodeW-1:0] from_node = 0, to_node = 0;
  logic [CountW-1:0] cfg_data = 0;
  logic busy, valid, last, edge_lost;
  logic [NodeW-1:0] node;

  dfs_topological_sort u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .from_node(from_node), .to_node(to_node), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .valid(valid), .node(node), .last(last),
    .edge_lost(edge_lost)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  int unsigned node_cnt;
  int unsigned head_q[NODES];
  int unsigned tail_q[NODES];
  int unsigned tgt_q[EDGES];
  int unsigned link_q[EDGES];
  int unsigned used_cnt;
  bit seen[NODES];
  bit dropped;
  order_t order_exp[$];

  int errors = 0;
  int cycles = 0;
  int runs = 0, edge_items = 0, results_seen = 0;

  task automatic report(input string what);
    errors++;
    $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic void graph_clear();
    for (int i = 0; i < NODES; i++) begin
      head_q[i] = EDGES;
      seen[i] = 0;
    end
    used_cnt = 0;
    dropped = 0;
  endfunction

  function automatic void count_write(input int unsigned v);
    v = v & 7'h7f;
    if (v < 1) v = 1;
    if (v > NODES) v = NODES;
    node_cnt = v;
  endfunction

  function automatic void edge_add(input int unsigned f, input int unsigned t);
    int unsigned e;
    if (used_cnt >= EDGES || f >= node_cnt || t >= node_cnt) begin
      dropped = 1;
      return;
    end
    e = used_cnt++;
    tgt_q[e] = t;
    link_q[e] = EDGES;
    if (head_q[f] >= EDGES) head_q[f] = e;
    else link_q[tail_q[f]] = e;
    tail_q[f] = e;
  endfunction

  function automatic void sort_predict();
    int unsigned stk_n[NODES];
    int unsigned stk_c[NODES];
    int unsigned fin[NODES];
    int unsigned done, sp, top, cur, t;
    order_t r;
    done = 0;
    for (int unsigned root = 0; root < node_cnt; root++) begin
      if (seen[root]) continue;
      seen[root] = 1;
      stk_n[0] = root;
      stk_c[0] = head_q[root];
      sp = 1;
      while (sp > 0) begin
        top = sp - 1;
        cur = stk_c[top];
        if (cur < used_cnt) begin
          t = tgt_q[cur];
          stk_c[top] = link_q[cur];
          if (t < node_cnt && !seen[t] && sp < NODES) begin
            seen[t] = 1;
            stk_n[sp] = t;
            stk_c[sp] = head_q[t];
            sp++;
          end
        end else begin
          if (done < NODES) fin[done++] = stk_n[top];
          sp--;
        end
      end
    end
    for (int unsigned k = 0; k < done; k++) begin
      r.node = NodeW'(fin[done - 1 - k]);
      r.last = (k + 1 == done);
      r.edge_lost = dropped;
      order_exp = {order_exp, r};
    end
    graph_clear();
  endfunction

  // result checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dfs_topological_sort_tb NOT OK");
      $finish;
    end
    if (!rst && valid) begin
      order_t e;
      results_seen <= results_seen + 1;
      if (order_exp.size() == 0) begin
        report($sformatf("unexpected result node=%0d", node));
      end else begin
        e = order_exp.pop_front();
        if (node !== e.node)
          report($sformatf("node got %0d exp %0d", node, e.node));
        if (last !== e.last)
          report($sformatf("last got %0b exp %0b (node %0d)", last, e.last, e.node));
        if (edge_lost !== e.edge_lost)
          report($sformatf("edge_lost got %0b exp %0b", edge_lost, e.edge_lost));
      end
    end
  end

  bit quiet = 0;

  task automatic send(input kind_e k, input int f, input int t);
    while (!quiet && $urandom_range(99) < 9) @(posedge clk);
    start <= 1'b1;
    kind <= k;
    from_node <= NodeW'(f);
    to_node <= NodeW'(t);
    @(posedge clk);
    while (busy) @(posedge clk);
    // transfer was taken at the edge that raised busy
    start <= 1'b0;
    if (k == K_RUN) begin
      sort_predict();
      runs++;
    end else begin
      edge_add(f, t);
      edge_items++;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    while (order_exp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_count(input int v);
    drain();
    cfg_we <= 1;
    cfg_data <= CountW'(v);
    @(posedge clk);
    cfg_we <= 0;
    count_write(v);
  endtask

  typedef struct {
    kind_e k;
    int    f;
    int    t;
    int    exp_node; // -1 when only predictor checked
  } row_t;

  row_t dir_rows[12] = '{
    '{K_RUN, 63, 63, 63},
    '{K_EDGE, 0, 1, -1}, '{K_EDGE, 1, 2, -1}, '{K_EDGE, 2, 0, -1},
    '{K_EDGE, 2, 3, -1}, '{K_EDGE, 63, 0, -1}, '{K_EDGE, 0, 63, -1},
    '{K_RUN, 0, 0, 62},
    '{K_EDGE, 3, 3, -1}, '{K_EDGE, 5, 4, -1}, '{K_EDGE, 5, 4, -1},
    '{K_RUN, 42, 21, -1}
  };

  initial begin
    int n, hi;
    node_cnt = NODES;
    graph_clear();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      int before_sz;
      before_sz = order_exp.size();
      send(dir_rows[i].k, dir_rows[i].f, dir_rows[i].t);
      if (dir_rows[i].exp_node >= 0 && order_exp.size() > before_sz &&
          order_exp[before_sz].node != dir_rows[i].exp_node)
        report($sformatf("directed row %0d predicts %0d", i, order_exp[before_sz].node));
    end

    // small count: out of range edges and lowered count after load
    set_count(4);
    send(K_EDGE, 0, 4);
    send(K_EDGE, 3, 0);
    send(K_EDGE, 1, 3);
    send(K_RUN, 0, 0);
    send(K_EDGE, 1, 2);
    set_count(1);
    send(K_RUN, 0, 0);
    set_count(0);
    send(K_EDGE, 0, 0);
    send(K_RUN, 0, 0);
    set_count(127);
    send(K_EDGE, 10, 11);
    set_count(12);
    send(K_RUN, 0, 0);

    // pool overflow
    set_count(64);
    for (int i = 0; i < EDGES + 3; i++) send(K_EDGE, $urandom_range(63), $urandom_range(63));
    send(K_RUN, 0, 0);

    // random graphs, mostly well formed
    n = 0;
    while (n < 170) begin
      int v;
      v = $urandom_range(9);
      if (v < 3) v = $urandom_range(2, 8);
      else if (v < 8) v = $urandom_range(9, 24);
      else if (v < 9) v = 64;
      else v = $urandom_range(0, 127);
      set_count(v);
      quiet = (n >= 50 && n < 120);
      hi = node_cnt < 64 && $urandom_range(4) == 0 ? node_cnt : node_cnt - 1;
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(19) == 0)
          send(K_EDGE, $urandom_range(63), $urandom_range(63));
        else
          send(K_EDGE, $urandom_range(hi), $urandom_range(hi));
        n++;
      end
      if ($urandom_range(5) == 0) set_count($urandom_range(1, 64));
      send(K_RUN, $urandom_range(63), $urandom_range(63));
      n++;
    end
    quiet = 0;

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d edge transfers and %0d sort runs, %0d results checked",
             edge_items, runs, results_seen);
    if (errors == 0 && order_exp.size() == 0) begin
      $display("dfs_topological_sort_tb OK");
    end else begin
      $display("dfs_topological_sort_tb NOT OK");
    end
    $finish;
  end
endmodule

### sim.f
sv/dts_pkg.sv
sv/dts_ram.sv
sv/dfs_topological_sort.sv
bench/dfs_topological_sort_tb.sv
